/* hdl/assert_macros.svh */
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AM_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define AM_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/acl_pkg.sv */
package acl_pkg;

    // rule table size and derived widths
    localparam int RULES = 1024;
    localparam int IDX_W = $clog2(RULES);
    localparam int CNT_W = $clog2(RULES + 1);

    // function and result kind codes
    localparam logic FUNC_INSERT   = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;
    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // request word
    typedef struct packed {
        logic        func;
        logic [19:0] priority_req;
        logic [7:0]  proto;
        logic        proto_exact;
        logic [31:0] src_addr;
        logic [5:0]  src_len;
        logic [31:0] dst_addr;
        logic [5:0]  dst_len;
        logic [15:0] src_port_lo;
        logic [15:0] src_port_hi;
        logic [15:0] dst_port_lo;
        logic [15:0] dst_port_hi;
    } acl_req_t;

    // response word
    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [19:0] best_priority;
    } acl_rsp_t;

    // one rule as held in a cell, prefixes kept as address and mask
    typedef struct packed {
        logic [19:0] prio;
        logic        proto_exact;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [15:0] sp_lo;
        logic [15:0] sp_hi;
        logic [15:0] dp_lo;
        logic [15:0] dp_hi;
    } acl_rule_t;

    // token moving down the cell row
    // cnt: rule count seen at entry; hit/best: insert stored flag, or running best match
    typedef struct packed {
        logic             func;
        logic [CNT_W-1:0] cnt;
        logic             hit;
        logic [19:0]      best;
        acl_rule_t        rule;
    } acl_tok_t;

    // prefix length to address mask, lengths above 32 act as 32
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [5:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        return 32'hFFFF_FFFF << (6'd32 - l);
    endfunction

endpackage

/* hdl/acl_five_tuple_classifier_top.sv */
// a request passes through all acl_pkg::RULES rule cells to reach the response,
// one register per rule cell; throughput: one word per cycle while not stalled,
// inserts and classifications freely mixed
// a response stall freezes the whole cell row and stalls the request side
// reset clears the rule count and all token valid bits; rule storage is not cleared
`include "assert_macros.svh"

module acl_five_tuple_classifier_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  acl_pkg::acl_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output acl_pkg::acl_rsp_t rsp
);

    logic                      en;
    logic                      accept;
    logic                      room;
    logic                      ins_take;
    logic                      rsp_ins;
    logic                      rsp_miss;
    logic [acl_pkg::CNT_W-1:0] cnt_reg;
    logic [acl_pkg::CNT_W-1:0] cnt_next;
    acl_pkg::acl_tok_t         tok0;
    logic                      chain_valid [acl_pkg::RULES+1];
    acl_pkg::acl_tok_t         chain_tok   [acl_pkg::RULES+1];

    // global advance: hold everything while the last cell's word is stalled
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;
    assign accept    = req_valid && en;
    assign room      = cnt_reg < acl_pkg::CNT_W'(acl_pkg::RULES);
    assign ins_take  = accept && (req.func == acl_pkg::FUNC_INSERT) && room;

    // rule count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ins_take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // build the entry token
    always_comb
    begin
        tok0.func             = req.func;
        tok0.cnt              = cnt_reg;
        tok0.hit              = (req.func == acl_pkg::FUNC_INSERT) && room;
        tok0.best             = '0;
        tok0.rule.prio        = req.priority_req;
        tok0.rule.proto_exact = req.proto_exact;
        tok0.rule.proto       = req.proto;
        tok0.rule.src_addr    = req.src_addr;
        tok0.rule.src_mask    = acl_pkg::len_mask(req.src_len);
        tok0.rule.dst_addr    = req.dst_addr;
        tok0.rule.dst_mask    = acl_pkg::len_mask(req.dst_len);
        tok0.rule.sp_lo       = req.src_port_lo;
        tok0.rule.sp_hi       = req.src_port_hi;
        tok0.rule.dp_lo       = req.dst_port_lo;
        tok0.rule.dp_hi       = req.dst_port_hi;
    end

    assign chain_valid[0] = req_valid;
    assign chain_tok[0]   = tok0;

    // row of rule cells
    genvar i;
    generate
        for (i = 0; i < acl_pkg::RULES; i++)
        begin : g_cell
            acl_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .idx       (acl_pkg::IDX_W'(i)),
                .tok_valid (chain_valid[i]),
                .tok       (chain_tok[i]),
                .out_valid (chain_valid[i+1]),
                .out_tok   (chain_tok[i+1])
            );
        end
    endgenerate

    // response from the last cell
    assign rsp_valid         = chain_valid[acl_pkg::RULES];
    assign rsp.kind          = chain_tok[acl_pkg::RULES].func;
    assign rsp.ok            = chain_tok[acl_pkg::RULES].hit;
    assign rsp.best_priority = chain_tok[acl_pkg::RULES].best;

    // response classes seen by the checks
    assign rsp_ins  = rsp_valid && (rsp.kind == acl_pkg::KIND_INSERT);
    assign rsp_miss = rsp_valid && (rsp.kind == acl_pkg::KIND_CLASSIFY) && !rsp.ok;

    // checks
    `AM_IMPLIES(a_cnt_max, 1'b1, cnt_reg <= acl_pkg::CNT_W'(acl_pkg::RULES), "count overflow")
    `AM_NEXT(a_cnt_inc, ins_take, cnt_reg == $past(cnt_reg) + 1'b1, "insert did not bump count")
    `AM_IMPLIES(a_ins_zero, rsp_ins, rsp.best_priority == 20'h0, "insert answer nonzero")
    `AM_IMPLIES(a_miss_zero, rsp_miss, rsp.best_priority == 20'h0, "miss with nonzero priority")

endmodule

/* hdl/acl_cell.sv */
module acl_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [acl_pkg::IDX_W-1:0]      idx,
    input  logic                           tok_valid,
    input  acl_pkg::acl_tok_t              tok,
    output logic                           out_valid,
    output acl_pkg::acl_tok_t              out_tok
);

    logic              valid_reg;
    acl_pkg::acl_tok_t tok_reg;
    acl_pkg::acl_tok_t tok_next;
    acl_pkg::acl_rule_t rule_reg;
    logic              live;
    logic              rule_match;
    logic              take;
    logic              write;

    // this cell holds a stored rule for tokens that entered after its insert
    assign live = acl_pkg::CNT_W'(idx) < tok.cnt;

    // five-tuple compare against the stored rule
    assign rule_match =
        (!rule_reg.proto_exact || (rule_reg.proto == tok.rule.proto)) &&
        (((tok.rule.src_addr ^ rule_reg.src_addr) & rule_reg.src_mask) == 32'h0) &&
        (((tok.rule.dst_addr ^ rule_reg.dst_addr) & rule_reg.dst_mask) == 32'h0) &&
        (tok.rule.sp_lo >= rule_reg.sp_lo) && (tok.rule.sp_lo <= rule_reg.sp_hi) &&
        (tok.rule.dp_lo >= rule_reg.dp_lo) && (tok.rule.dp_lo <= rule_reg.dp_hi);

    // classify token picks up a better priority
    assign take = tok_valid && (tok.func == acl_pkg::FUNC_CLASSIFY) && live && rule_match &&
                  (!tok.hit || (rule_reg.prio < tok.best));

    // insert token lands in the cell matching its slot
    assign write = en && tok_valid && (tok.func == acl_pkg::FUNC_INSERT) &&
                   (tok.cnt == acl_pkg::CNT_W'(idx));

    always_comb
    begin
        tok_next = tok;
        if (take)
        begin
            tok_next.hit  = 1'b1;
            tok_next.best = rule_reg.prio;
        end
    end

    // token valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tok_valid;
        end
    end

    // token payload and stored rule
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
        end
        if (write)
        begin
            rule_reg <= tok.rule;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

/* dv/tb_acl_five_tuple_classifier_top.sv */
module tb_acl_five_tuple_classifier_top;

    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int RANDOM_WORDS   = 620;
    localparam int PRESSURE_WORDS = 60;

    // table of accepted rules and the answers still owed by the block
    class acl_scoreboard;
        acl_pkg::acl_req_t stored[$];
        acl_pkg::acl_rsp_t answers_due[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR %0t: %s", $time, msg);
        endfunction

        // top len bits equal, lengths above 32 clamp to 32, zero is a wildcard
        function bit prefix_hit(logic [31:0] addr, logic [31:0] pfx, logic [5:0] len);
            int l;
            l = (len > 6'd32) ? 32 : int'(len);
            if (l == 0)
                return 1'b1;
            return ((addr ^ pfx) >> (32 - l)) == 32'd0;
        endfunction

        // lowest priority among rules that cover the packet
        function acl_pkg::acl_rsp_t best_match(acl_pkg::acl_req_t pkt);
            acl_pkg::acl_rsp_t r;
            r.kind          = acl_pkg::KIND_CLASSIFY;
            r.ok            = 1'b0;
            r.best_priority = '0;
            foreach (stored[k]) begin
                if (stored[k].proto_exact && stored[k].proto != pkt.proto)
                    continue;
                if (!prefix_hit(pkt.src_addr, stored[k].src_addr, stored[k].src_len))
                    continue;
                if (!prefix_hit(pkt.dst_addr, stored[k].dst_addr, stored[k].dst_len))
                    continue;
                if (pkt.src_port_lo < stored[k].src_port_lo ||
                    pkt.src_port_lo > stored[k].src_port_hi)
                    continue;
                if (pkt.dst_port_lo < stored[k].dst_port_lo ||
                    pkt.dst_port_lo > stored[k].dst_port_hi)
                    continue;
                if (!r.ok || stored[k].priority_req < r.best_priority) begin
                    r.ok            = 1'b1;
                    r.best_priority = stored[k].priority_req;
                end
            end
            return r;
        endfunction

        function void note_request(acl_pkg::acl_req_t w);
            acl_pkg::acl_rsp_t r;
            r = '0;
            if (w.func == acl_pkg::FUNC_INSERT) begin
                r.kind = acl_pkg::KIND_INSERT;
                if (stored.size() < acl_pkg::RULES) begin
                    stored.push_back(w);
                    r.ok = 1'b1;
                end
            end
            else begin
                r = best_match(w);
            end
            answers_due.push_back(r);
        endfunction

        function void check_response(acl_pkg::acl_rsp_t got);
            acl_pkg::acl_rsp_t want;
            if (answers_due.size() == 0) begin
                flag($sformatf("unexpected word: kind=%0b ok=%0b prio=%05h",
                    got.kind, got.ok, got.best_priority));
                return;
            end
            want = answers_due.pop_front();
            if (got.kind !== want.kind || got.ok !== want.ok ||
                got.best_priority !== want.best_priority)
                flag($sformatf("expected kind=%0b ok=%0b prio=%05h, got kind=%0b ok=%0b prio=%05h",
                    want.kind, want.ok, want.best_priority,
                    got.kind, got.ok, got.best_priority));
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              rsp_stall = 1'b0;
    acl_pkg::acl_req_t req       = '0;
    logic              req_stall;
    logic              rsp_valid;
    acl_pkg::acl_rsp_t rsp;

    acl_scoreboard sb;
    bit idle_on   = 1'b0;
    int hold_asks = 0;

    acl_five_tuple_classifier_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // word builders
    function automatic acl_pkg::acl_req_t mk_rule(
        input logic [19:0] prio, input logic ex, input logic [7:0] pr,
        input logic [31:0] sa, input logic [5:0] sl,
        input logic [31:0] da, input logic [5:0] dl,
        input logic [15:0] splo, input logic [15:0] sphi,
        input logic [15:0] dplo, input logic [15:0] dphi);
        acl_pkg::acl_req_t w;
        w.func         = acl_pkg::FUNC_INSERT;
        w.priority_req = prio;
        w.proto        = pr;
        w.proto_exact  = ex;
        w.src_addr     = sa;
        w.src_len      = sl;
        w.dst_addr     = da;
        w.dst_len      = dl;
        w.src_port_lo  = splo;
        w.src_port_hi  = sphi;
        w.dst_port_lo  = dplo;
        w.dst_port_hi  = dphi;
        return w;
    endfunction

    function automatic acl_pkg::acl_req_t mk_pkt(input logic [7:0] pr, input logic [31:0] sa,
        input logic [31:0] da, input logic [15:0] sp, input logic [15:0] dp);
        acl_pkg::acl_req_t w;
        w             = '0;
        w.func        = acl_pkg::FUNC_CLASSIFY;
        w.proto       = pr;
        w.src_addr    = sa;
        w.dst_addr    = da;
        w.src_port_lo = sp;
        w.dst_port_lo = dp;
        return w;
    endfunction

    function automatic acl_pkg::acl_req_t noise_word();
        acl_pkg::acl_req_t w;
        w.func         = 1'($urandom);
        w.priority_req = 20'($urandom);
        w.proto        = 8'($urandom);
        w.proto_exact  = 1'($urandom);
        w.src_addr     = $urandom;
        w.src_len      = 6'($urandom);
        w.dst_addr     = $urandom;
        w.dst_len      = 6'($urandom);
        w.src_port_lo  = 16'($urandom);
        w.src_port_hi  = 16'($urandom);
        w.dst_port_lo  = 16'($urandom);
        w.dst_port_hi  = 16'($urandom);
        return w;
    endfunction

    function automatic logic [5:0] rand_len();
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'($urandom_range(33, 63));
            2: return 6'd32;
            default: return 6'($urandom_range(1, 31));
        endcase
    endfunction

    // port range packed as {hi, lo}; includes full, single-port and empty ranges
    function automatic logic [31:0] rand_span();
        int lo;
        int hi;
        case ($urandom_range(0, 5))
            0: begin
                lo = 0;
                hi = 65535;
            end
            1: begin
                lo = $urandom_range(1, 65535);
                hi = $urandom_range(0, lo - 1);
            end
            2: begin
                lo = $urandom_range(0, 65535);
                hi = lo;
            end
            default: begin
                lo = $urandom_range(0, 65535);
                hi = lo + $urandom_range(0, 4095);
                if (hi > 65535)
                    hi = 65535;
            end
        endcase
        return {16'(hi), 16'(lo)};
    endfunction

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        int l;
        l = (len > 6'd32) ? 32 : int'(len);
        if (l == 0)
            return 32'd0;
        return 32'hFFFF_FFFF << (32 - l);
    endfunction

    function automatic acl_pkg::acl_req_t rand_rule();
        acl_pkg::acl_req_t w;
        logic [31:0] sp;
        logic [31:0] dp;
        w              = noise_word();
        w.func         = acl_pkg::FUNC_INSERT;
        sp             = rand_span();
        dp             = rand_span();
        w.priority_req = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                     : 20'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: w.proto = 8'd6;
            1: w.proto = 8'd17;
            default: w.proto = 8'($urandom);
        endcase
        w.proto_exact = ($urandom_range(0, 3) != 0);
        w.src_len     = rand_len();
        w.dst_len     = rand_len();
        {w.src_port_hi, w.src_port_lo} = sp;
        {w.dst_port_hi, w.dst_port_lo} = dp;
        return w;
    endfunction

    // mostly headers aimed at a stored rule, some near misses, the rest noise
    function automatic acl_pkg::acl_req_t rand_packet();
        acl_pkg::acl_req_t w;
        acl_pkg::acl_req_t r;
        logic [31:0] m;
        w      = noise_word();
        w.func = acl_pkg::FUNC_CLASSIFY;
        if (sb.stored.size() > 0 && $urandom_range(0, 3) != 0) begin
            r = sb.stored[$urandom_range(0, sb.stored.size() - 1)];
            if (r.proto_exact)
                w.proto = r.proto;
            m = prefix_mask(r.dst_len);
            w.dst_addr = (r.dst_addr & m) | (w.dst_addr & ~m);
            m = prefix_mask(r.src_len);
            w.src_addr = (r.src_addr & m) | (w.src_addr & ~m);
            if (r.src_port_lo <= r.src_port_hi)
                w.src_port_lo = 16'($urandom_range(r.src_port_hi, r.src_port_lo));
            if (r.dst_port_lo <= r.dst_port_hi)
                w.dst_port_lo = 16'($urandom_range(r.dst_port_hi, r.dst_port_lo));
            // flip the last bit of the source prefix
            if ($urandom_range(0, 4) == 0)
                w.src_addr = w.src_addr ^ (m & (~m + 32'd1));
        end
        return w;
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(input acl_pkg::acl_req_t w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(w);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.answers_due.size() != 0)
            @(posedge clk);
    endtask

    // response side: check accepted words, random stall bursts, one long hold
    initial
    begin : rsp_side
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                rsp_stall <= 1'b1;
            end
            else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        acl_pkg::acl_req_t w;
        int n;
        sb = new();

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // classify against an empty table
        send_word(mk_pkt(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));

        // directed rules: exact /32 source, long prefixes, empty range, typical, all zero, all ones
        send_word(mk_rule(20'hFFFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 6'd32, 32'h0, 6'd0,
                          16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        send_word(mk_rule(20'h00000, 1'b0, 8'h00, 32'h0A00_0001, 6'd63, 32'hC0A8_0001, 6'd33,
                          16'd80, 16'd80, 16'd0, 16'd0));
        send_word(mk_rule(20'd5, 1'b0, 8'h11, 32'h0, 6'd0, 32'h0, 6'd0,
                          16'd100, 16'd50, 16'h0000, 16'hFFFF));
        send_word(mk_rule(20'h12345, 1'b1, 8'd6, 32'h0A00_0000, 6'd8, 32'hAC10_0000, 6'd12,
                          16'd1024, 16'hFFFF, 16'd443, 16'd443));
        send_word(mk_rule('0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_word(mk_rule('1, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1));

        // directed headers: hits, prefix and port misses, empty range
        send_word(mk_pkt(8'hFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF));
        send_word(mk_pkt(8'h00, 32'h0, 32'h0, 16'h0, 16'h0));
        send_word(mk_pkt(8'd17, 32'h0A00_0001, 32'hC0A8_0001, 16'd80, 16'd0));
        send_word(mk_pkt(8'd17, 32'h0A00_0002, 32'hC0A8_0001, 16'd80, 16'd0));
        send_word(mk_pkt(8'd1, 32'h1, 32'h1, 16'd75, 16'd75));
        send_word(mk_pkt(8'd6, 32'h0A12_3456, 32'hAC1F_FFFF, 16'd2000, 16'd443));
        send_word(mk_pkt(8'd6, 32'h0A12_3456, 32'hAC20_0000, 16'd2000, 16'd443));
        send_word(mk_pkt(8'd6, 32'h0A00_0000, 32'hAC10_0000, 16'd1024, 16'd442));
        w = mk_pkt(8'hFF, '1, '1, '1, '1);
        w.priority_req = '1;
        w.proto_exact  = 1'b1;
        w.src_len      = '1;
        w.dst_len      = '1;
        w.src_port_hi  = '1;
        w.dst_port_hi  = '1;
        send_word(w);

        // sender pause until every answer is back
        wait_drained();

        // random mix with idling on both sides
        idle_on = 1'b1;
        for (n = 0; n < RANDOM_WORDS; n++)
            send_word(($urandom_range(0, 99) < 45) ? rand_rule() : rand_packet());
        idle_on = 1'b0;

        // long response hold while the sender keeps offering
        for (n = 0; n < PRESSURE_WORDS; n++) begin
            if (n == 10)
                hold_asks++;
            send_word(rand_rule());
            if (n % 4 == 3)
                send_word(rand_packet());
        end
        for (n = 0; n < 40; n++)
            send_word(rand_packet());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.answers_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/acl_pkg.sv
hdl/acl_cell.sv
hdl/acl_five_tuple_classifier_top.sv
dv/tb_acl_five_tuple_classifier_top.sv
